// ===== hdl/c3acc_pkg.sv =====
`timescale 1ns / 1ps

package c3acc_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int WEIGHT_W    = 16;
    localparam int ADDEND_W    = 40;
    localparam int RESULT_W    = 40;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int WIDTH_CFG_W = 11;
    localparam int HEIGHT_W    = 16;
    localparam int HEIGHT_LIMIT = 65533;
    localparam int TAPS        = 3;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int CELL_SUM_W  = PROD_W + 2;
    localparam int WIN_SUM_W   = CELL_SUM_W + 2;
    localparam int ACC_W       = RESULT_W + 1;
    localparam int OUT_DEPTH   = 8;
    localparam int CREDIT_W    = $clog2(OUT_DEPTH + 1);

    localparam logic signed [RESULT_W-1:0] RES_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
    localparam logic signed [RESULT_W-1:0] RES_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

    typedef logic signed [SAMPLE_W-1:0]   sample_t;
    typedef logic signed [WEIGHT_W-1:0]   weight_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [CELL_SUM_W-1:0] cell_sum_t;
    typedef logic signed [WIN_SUM_W-1:0]  win_sum_t;
    typedef logic signed [ACC_W-1:0]      acc_t;

    // One window column: element 0 is the oldest row
    typedef sample_t [TAPS-1:0] column_t;
    typedef weight_t [TAPS-1:0] weight_col_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_ROW0 = 3'd0,
        REG_WEIGHT_ROW1 = 3'd1,
        REG_WEIGHT_ROW2 = 3'd2,
        REG_OUT_WIDTH   = 3'd3,
        REG_OUT_HEIGHT  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] src_sample;
        logic signed [ADDEND_W-1:0] addend;
    } src_item_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result;
        logic                       saturated;
        logic                       frame_end;
    } dst_item_t;

endpackage

// ===== hdl/c3acc_if.sv =====
`timescale 1ns / 1ps

interface c3acc_src_if import c3acc_pkg::*;;
    logic      valid;
    logic      ready;
    src_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface c3acc_dst_if import c3acc_pkg::*;;
    logic      valid;
    logic      ready;
    dst_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface c3acc_cfg_if import c3acc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/c3acc_ram.sv =====
`timescale 1ns / 1ps

module c3acc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1026
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/c3acc_cell.sv =====
`timescale 1ns / 1ps

module c3acc_cell import c3acc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  column_t     shift_in,
    input  weight_col_t weights,
    output column_t     taps,
    output cell_sum_t   sum
);

    column_t   taps_reg;
    prod_t     prod_reg [TAPS];
    cell_sum_t sum_reg;

    // Hold the column until the next sample transfer moves the window left
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg <= '0;
        end
        else if (load)
        begin
            taps_reg <= shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            prod_reg[i] <= prod_t'($signed(taps_reg[i]) * $signed(weights[i]));
        end
        sum_reg <= cell_sum_t'(prod_reg[0]) + cell_sum_t'(prod_reg[1])
                 + cell_sum_t'(prod_reg[2]);
    end

    assign taps = taps_reg;
    assign sum  = sum_reg;

endmodule

// ===== hdl/c3acc_out_fifo.sv =====
`timescale 1ns / 1ps

module c3acc_out_fifo import c3acc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  dst_item_t push_item,
    c3acc_dst_if.source dst
);

    localparam int PtrW = $clog2(OUT_DEPTH);

    dst_item_t           entry_reg [OUT_DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [CREDIT_W-1:0] count_reg;
    logic [CREDIT_W-1:0] count_next;
    logic                pop;

    assign pop       = dst.valid && dst.ready;
    assign dst.valid = (count_reg != '0);
    assign dst.data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CREDIT_W'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - CREDIT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PtrW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/conv3x3_accumulate_stream.sv =====
`timescale 1ns / 1ps

// 3x3 convolution with accumulate over a raster-order sample stream. The block
// takes one source sample per clock while src.ready is high and gives one
// result for every sample at source row >= 2 and column >= 2; result =
// addend + sum of nine Q2.14 weight x Q8.8 sample products, saturated to 40
// bits. A result is queued after the window cells and the sum register; the
// queue holds 8 results, and src.ready drops while 8 results are owed to the
// sink. The two previous source rows live in two RAMs of MAX_WIDTH+2 entries,
// read ahead of the window load; the window is a row of three column cells,
// each with three multipliers. No clearing pass runs after reset. Write the
// size and weight registers only while no result is outstanding.
module conv3x3_accumulate_stream import c3acc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    c3acc_cfg_if.sink   cfg,
    c3acc_src_if.sink   src,
    c3acc_dst_if.source dst
);

    localparam int LineDepth = MAX_WIDTH + 2;
    localparam int ColW      = $clog2(LineDepth);
    localparam int PipeLen   = 4;

    // Configuration
    logic [CFG_DATA_W-1:0] weight_row_reg [TAPS];
    logic [ColW-1:0]       last_col_reg;
    logic [HEIGHT_W-1:0]   last_row_reg;
    logic [ColW-1:0]       last_col_cfg;
    logic [HEIGHT_W-1:0]   last_row_cfg;
    int                    w_raw;
    int                    w_eff;
    int                    h_raw;
    int                    h_eff;

    // Raster position
    logic [ColW-1:0]     col_reg;
    logic [HEIGHT_W-1:0] row_reg;
    logic                accept;
    logic                emit_now;
    logic                frame_end_now;

    // Line buffer stage
    logic            s1_valid_reg;
    logic            s1_emit_reg;
    logic            s1_fe_reg;
    sample_t         s1_sample_reg;
    logic signed [ADDEND_W-1:0] s1_addend_reg;
    logic [ColW-1:0] s1_col_reg;
    logic [SAMPLE_W-1:0] upper_rdata;
    logic [SAMPLE_W-1:0] lower_rdata;

    // Result pipeline, one slot per register after the window load
    logic                       p_emit_reg   [PipeLen];
    logic                       p_fe_reg     [PipeLen];
    logic signed [ADDEND_W-1:0] p_addend_reg [PipeLen];
    win_sum_t                   psum_reg;

    column_t     new_col;
    column_t     cell_taps [TAPS];
    cell_sum_t   cell_sum  [TAPS];
    weight_col_t cell_w    [TAPS];

    acc_t      acc;
    dst_item_t push_item;
    logic      push;

    logic [CREDIT_W-1:0] credit_reg;
    logic [CREDIT_W-1:0] credit_next;
    logic                reserve;
    logic                release_slot;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_comb
    begin
        w_raw = int'(cfg.data[WIDTH_CFG_W-1:0]);
        h_raw = int'(cfg.data[HEIGHT_W-1:0]);
        if (w_raw == 0)
        begin
            w_eff = 1;
        end
        else if (w_raw > MAX_WIDTH)
        begin
            w_eff = MAX_WIDTH;
        end
        else
        begin
            w_eff = w_raw;
        end
        if (h_raw == 0)
        begin
            h_eff = 1;
        end
        else if (h_raw > HEIGHT_LIMIT)
        begin
            h_eff = HEIGHT_LIMIT;
        end
        else
        begin
            h_eff = h_raw;
        end
        last_col_cfg = ColW'(w_eff + 1);
        last_row_cfg = HEIGHT_W'(h_eff + 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                weight_row_reg[i] <= '0;
            end
            last_col_reg <= ColW'(2);
            last_row_reg <= HEIGHT_W'(2);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_WEIGHT_ROW0: weight_row_reg[0] <= cfg.data;
                REG_WEIGHT_ROW1: weight_row_reg[1] <= cfg.data;
                REG_WEIGHT_ROW2: weight_row_reg[2] <= cfg.data;
                REG_OUT_WIDTH:   last_col_reg      <= last_col_cfg;
                REG_OUT_HEIGHT:  last_row_reg      <= last_row_cfg;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input side: raster counters and output credits
    // ------------------------------------------------------------------
    assign src.ready     = (credit_reg < CREDIT_W'(OUT_DEPTH));
    assign accept        = src.valid && src.ready;
    assign emit_now      = (row_reg >= HEIGHT_W'(2)) && (col_reg >= ColW'(2));
    assign frame_end_now = (col_reg >= last_col_reg) && (row_reg >= last_row_reg);

    assign reserve      = accept && emit_now;
    assign release_slot = dst.valid && dst.ready;

    always_comb
    begin
        credit_next = credit_reg;
        if (reserve && !release_slot)
        begin
            credit_next = credit_reg + CREDIT_W'(1);
        end
        else if (!reserve && release_slot)
        begin
            credit_next = credit_reg - CREDIT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            credit_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            credit_reg   <= credit_next;
            s1_valid_reg <= accept;
            if (accept)
            begin
                // Wrap at the last column, and at the frame end also the row
                if (col_reg >= last_col_reg)
                begin
                    col_reg <= '0;
                    if (row_reg >= last_row_reg)
                    begin
                        row_reg <= '0;
                    end
                    else
                    begin
                        row_reg <= row_reg + HEIGHT_W'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + ColW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg   <= emit_now;
            s1_fe_reg     <= frame_end_now;
            s1_sample_reg <= src.data.src_sample;
            s1_addend_reg <= src.data.addend;
            s1_col_reg    <= col_reg;
        end
    end

    // ------------------------------------------------------------------
    // Line buffers: read at transfer, write back from the s1 registers later
    // ------------------------------------------------------------------
    c3acc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LineDepth)
    ) u_upper_line (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (lower_rdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (upper_rdata)
    );

    c3acc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LineDepth)
    ) u_lower_line (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_sample_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (lower_rdata)
    );

    // ------------------------------------------------------------------
    // Window: three column cells, the newest column enters on the right
    // ------------------------------------------------------------------
    always_comb
    begin
        new_col[0] = sample_t'(upper_rdata);
        new_col[1] = sample_t'(lower_rdata);
        new_col[2] = s1_sample_reg;
    end

    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        for (genvar i = 0; i < TAPS; i++)
        begin : g_w
            assign cell_w[k][i] = weight_t'(weight_row_reg[i][WEIGHT_W*k +: WEIGHT_W]);
        end

        if (k == TAPS - 1)
        begin : g_head
            c3acc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .load     (s1_valid_reg),
                .shift_in (new_col),
                .weights  (cell_w[k]),
                .taps     (cell_taps[k]),
                .sum      (cell_sum[k])
            );
        end
        else
        begin : g_body
            c3acc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .load     (s1_valid_reg),
                .shift_in (cell_taps[k+1]),
                .weights  (cell_w[k]),
                .taps     (cell_taps[k]),
                .sum      (cell_sum[k])
            );
        end
    end

    // ------------------------------------------------------------------
    // Sum, accumulate, saturate
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < PipeLen; s++)
            begin
                p_emit_reg[s] <= 1'b0;
            end
        end
        else
        begin
            p_emit_reg[0] <= s1_valid_reg && s1_emit_reg;
            for (int s = 1; s < PipeLen; s++)
            begin
                p_emit_reg[s] <= p_emit_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_fe_reg[0]     <= s1_fe_reg;
        p_addend_reg[0] <= s1_addend_reg;
        for (int s = 1; s < PipeLen; s++)
        begin
            p_fe_reg[s]     <= p_fe_reg[s-1];
            p_addend_reg[s] <= p_addend_reg[s-1];
        end
        psum_reg <= win_sum_t'(cell_sum[0]) + win_sum_t'(cell_sum[1])
                  + win_sum_t'(cell_sum[2]);
    end

    always_comb
    begin
        acc = acc_t'(p_addend_reg[PipeLen-1]) + acc_t'(psum_reg);
        push_item.frame_end = p_fe_reg[PipeLen-1];
        if (acc[ACC_W-1] != acc[ACC_W-2])
        begin
            push_item.saturated = 1'b1;
            push_item.result    = acc[ACC_W-1] ? RES_MIN : RES_MAX;
        end
        else
        begin
            push_item.saturated = 1'b0;
            push_item.result    = acc[RESULT_W-1:0];
        end
    end

    assign push = p_emit_reg[PipeLen-1];

    c3acc_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .dst       (dst)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CREDIT_W'(OUT_DEPTH))
        else $error("output credit count above queue depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_emit_reg |-> ##4 push)
        else $error("emitting sample did not reach the output queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_fe_reg |-> s1_emit_reg)
        else $error("frame end flagged on a sample that gives no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> credit_reg != '0)
        else $error("result queued without a reserved slot");

endmodule
